[rtl/dsched_pkg.sv]
// Package: shared types, constants and helper functions of the disk request scheduler.
package dsched_pkg;

  localparam int TRACK_W          = 16;
  localparam int SEEK_W           = 22;
  localparam int CYL_W            = 17;
  localparam int MAX_REQUESTS_DEF = 32;

  localparam logic [SEEK_W-1:0] SEEK_MAX  = {SEEK_W{1'b1}};
  localparam logic [CYL_W-1:0]  CYL_RESET = 17'd200;
  localparam logic [CYL_W-1:0]  CYL_CAP   = 17'h10000;

  typedef enum logic [1:0] {
    POL_SSTF  = 2'd0,
    POL_SCAN  = 2'd1,
    POL_CSCAN = 2'd2,
    POL_CLOOK = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    KIND_SERVE   = 2'd0,
    KIND_TURN    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_POLICY = 1'b0,
    CFG_CYL    = 1'b1
  } cfg_idx_t;

  // Which requests a table pass considers and what it minimizes.
  typedef enum logic [1:0] {
    RNG_NEAR  = 2'd0,  // any track, nearest to the head
    RNG_UPPER = 2'd1,  // start <= track < limit, smallest track
    RNG_FULL  = 2'd2,  // track < limit, largest track
    RNG_LOWER = 2'd3   // track < start, smallest track
  } range_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_ACT,
    S_TURN,
    S_WRAP,
    S_SUMMARY
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [TRACK_W-1:0] request_track;
    logic [TRACK_W-1:0] start_head;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [TRACK_W-1:0] track;
    logic [SEEK_W-1:0]  seek_total;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic   load;
    logic   init_run;
    logic   scan_start;
    logic   scan_run;
    logic   serve;
    logic   jump;
    logic   turn;
    logic   wrap;
    logic   summary;
    range_t rng;
  } dp_cmd_t;

  typedef struct packed {
    logic    scan_done;
    logic    found;
    policy_t policy;
  } dp_stat_t;

  function automatic logic [TRACK_W-1:0] track_dist(input logic [TRACK_W-1:0] a,
                                                   input logic [TRACK_W-1:0] b);
    track_dist = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [SEEK_W-1:0] sat_add(input logic [SEEK_W-1:0]  acc,
                                                input logic [TRACK_W-1:0] d);
    logic [SEEK_W:0] sum;
    sum = {1'b0, acc} + {{(SEEK_W+1-TRACK_W){1'b0}}, d};
    sat_add = sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];
  endfunction

endpackage

[rtl/dsched_ctrl.sv]
// Controller: run sequencing state machine of the disk request scheduler.
module dsched_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dsched_pkg::op_t     op,
  input  dsched_pkg::dp_stat_t stat,
  output dsched_pkg::dp_cmd_t cmd,
  output logic                busy
);

  dsched_pkg::state_t state_r, state_nxt;
  dsched_pkg::range_t ph_r, ph_nxt;
  logic               jumped_r, jumped_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dsched_pkg::S_IDLE;
      ph_r     <= dsched_pkg::RNG_NEAR;
      jumped_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ph_r     <= ph_nxt;
      jumped_r <= jumped_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    jumped_nxt = jumped_r;
    case (state_r)
      dsched_pkg::S_IDLE: begin
        if (start && op == dsched_pkg::OP_RUN) begin
          state_nxt = dsched_pkg::S_INIT;
        end
      end
      dsched_pkg::S_INIT: begin
        jumped_nxt = 1'b0;
        ph_nxt     = (stat.policy == dsched_pkg::POL_SSTF) ? dsched_pkg::RNG_NEAR
                                                           : dsched_pkg::RNG_UPPER;
        state_nxt  = dsched_pkg::S_SCAN;
      end
      dsched_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = dsched_pkg::S_ACT;
        end
      end
      dsched_pkg::S_ACT: begin
        if (stat.found) begin
          if (ph_r == dsched_pkg::RNG_LOWER && stat.policy == dsched_pkg::POL_CLOOK &&
              !jumped_r) begin
            jumped_nxt = 1'b1;
          end
          state_nxt = dsched_pkg::S_SCAN;
        end else begin
          case (ph_r)
            dsched_pkg::RNG_UPPER: begin
              if (stat.policy == dsched_pkg::POL_CLOOK) begin
                ph_nxt    = dsched_pkg::RNG_LOWER;
                state_nxt = dsched_pkg::S_SCAN;
              end else begin
                state_nxt = dsched_pkg::S_TURN;
              end
            end
            default: state_nxt = dsched_pkg::S_SUMMARY;
          endcase
        end
      end
      dsched_pkg::S_TURN: begin
        if (stat.policy == dsched_pkg::POL_SCAN) begin
          ph_nxt    = dsched_pkg::RNG_FULL;
          state_nxt = dsched_pkg::S_SCAN;
        end else begin
          state_nxt = dsched_pkg::S_WRAP;
        end
      end
      dsched_pkg::S_WRAP: begin
        ph_nxt    = dsched_pkg::RNG_LOWER;
        state_nxt = dsched_pkg::S_SCAN;
      end
      dsched_pkg::S_SUMMARY: state_nxt = dsched_pkg::S_IDLE;
      default:               state_nxt = dsched_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd            = '0;
    cmd.rng        = ph_r;
    busy           = (state_r != dsched_pkg::S_IDLE);
    cmd.load       = (state_r == dsched_pkg::S_IDLE) && start && (op == dsched_pkg::OP_LOAD);
    cmd.init_run   = (state_r == dsched_pkg::S_IDLE) && start && (op == dsched_pkg::OP_RUN);
    cmd.scan_start = (state_nxt == dsched_pkg::S_SCAN) && (state_r != dsched_pkg::S_SCAN);
    cmd.scan_run   = (state_r == dsched_pkg::S_SCAN);
    cmd.turn       = (state_r == dsched_pkg::S_TURN);
    cmd.wrap       = (state_r == dsched_pkg::S_WRAP);
    cmd.summary    = (state_r == dsched_pkg::S_SUMMARY);
    if (state_r == dsched_pkg::S_ACT && stat.found) begin
      if (ph_r == dsched_pkg::RNG_LOWER && stat.policy == dsched_pkg::POL_CLOOK && !jumped_r) begin
        cmd.jump = 1'b1;
      end else begin
        cmd.serve = 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsched_pkg::S_SUMMARY) |=> (state_r == dsched_pkg::S_IDLE))
    else $error("summary not followed by idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.jump |=> jumped_r)
    else $error("jump not recorded");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.serve, cmd.jump, cmd.turn, cmd.wrap, cmd.summary}))
    else $error("conflicting datapath commands");

endmodule

[rtl/dsched_dp.sv]
// Datapath: request table, pass-over-table search, head and seek registers, result register.
module dsched_dp #(
  parameter int MAX_REQUESTS = dsched_pkg::MAX_REQUESTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dsched_pkg::dp_cmd_t             cmd,
  input  dsched_pkg::in_item_t            in_data,
  input  logic                            cfg_we,
  input  dsched_pkg::cfg_idx_t            cfg_index,
  input  logic [dsched_pkg::CYL_W-1:0]    cfg_wdata,
  output dsched_pkg::dp_stat_t            stat,
  output logic                            out_valid,
  output dsched_pkg::out_item_t           out_data
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int TW    = dsched_pkg::TRACK_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  logic [TW-1:0]               mem [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0]     flag_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [TW-1:0]               head_r, start_r;
  logic [dsched_pkg::SEEK_W-1:0] acc_r, acc_nxt;
  dsched_pkg::policy_t         pol_r;
  logic [dsched_pkg::CYL_W-1:0] cyl_r;

  logic [CNT_W-1:0]            idx_r;
  logic                        pend_r;
  logic [IDX_W-1:0]            pidx_r;
  logic [TW-1:0]               rd_q;
  logic                        found_r;
  logic [IDX_W-1:0]            bidx_r;
  logic [TW-1:0]               bt_r, bkey_r;

  logic                        out_valid_r;
  dsched_pkg::out_item_t       out_data_r;

  logic [dsched_pkg::CYL_W-1:0] lim;
  logic [TW-1:0]               lim_m1;
  logic [TW-1:0]               start_cl;
  logic                        in_rng;
  logic [TW-1:0]               key;
  logic [TW-1:0]               amt;

  always_comb begin
    if (cyl_r == '0) begin
      lim = dsched_pkg::CYL_W'(1);
    end else if (cyl_r > dsched_pkg::CYL_CAP) begin
      lim = dsched_pkg::CYL_CAP;
    end else begin
      lim = cyl_r;
    end
    lim_m1   = TW'(lim - dsched_pkg::CYL_W'(1));
    start_cl = (in_data.start_head > lim_m1) ? lim_m1 : in_data.start_head;
  end

  // Candidate filter and sort key for the entry whose data just came back.
  always_comb begin
    case (cmd.rng)
      dsched_pkg::RNG_NEAR: begin
        in_rng = 1'b1;
        key    = dsched_pkg::track_dist(head_r, rd_q);
      end
      dsched_pkg::RNG_UPPER: begin
        in_rng = (rd_q >= start_r) && ({1'b0, rd_q} < lim);
        key    = rd_q;
      end
      dsched_pkg::RNG_FULL: begin
        in_rng = ({1'b0, rd_q} < lim);
        key    = ~rd_q;
      end
      dsched_pkg::RNG_LOWER: begin
        in_rng = (rd_q < start_r);
        key    = rd_q;
      end
      default: begin
        in_rng = 1'b0;
        key    = rd_q;
      end
    endcase
  end

  always_comb begin
    if (cmd.turn) begin
      amt = lim_m1 - head_r;
    end else if (cmd.wrap) begin
      amt = lim_m1;
    end else if (cmd.serve || cmd.jump) begin
      amt = dsched_pkg::track_dist(head_r, bt_r);
    end else begin
      amt = '0;
    end
    acc_nxt = dsched_pkg::sat_add(acc_r, amt);
  end

  // Request table.
  always_ff @(posedge clk) begin
    if (cmd.load && cnt_r < CNT_MAX && {1'b0, in_data.request_track} < lim) begin
      mem[cnt_r[IDX_W-1:0]] <= in_data.request_track;
    end
    if (cmd.scan_run && idx_r < cnt_r) begin
      rd_q <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      start_r     <= '0;
      acc_r       <= '0;
      pol_r       <= dsched_pkg::POL_SSTF;
      cyl_r       <= dsched_pkg::CYL_RESET;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dsched_pkg::CFG_POLICY: pol_r <= dsched_pkg::policy_t'(cfg_wdata[1:0]);
          dsched_pkg::CFG_CYL:    cyl_r <= cfg_wdata;
          default:                ;
        endcase
      end
      if (cmd.load && cnt_r < CNT_MAX && {1'b0, in_data.request_track} < lim) begin
        flag_r[cnt_r[IDX_W-1:0]] <= 1'b0;
        cnt_r                    <= cnt_r + CNT_W'(1);
      end
      if (cmd.init_run) begin
        start_r <= start_cl;
        head_r  <= start_cl;
        acc_r   <= '0;
      end
      if (cmd.serve || cmd.jump || cmd.turn || cmd.wrap) begin
        acc_r <= acc_nxt;
      end
      if (cmd.serve || cmd.jump) begin
        head_r <= bt_r;
      end
      if (cmd.turn) begin
        head_r <= lim_m1;
      end
      if (cmd.wrap) begin
        head_r <= '0;
      end
      if (cmd.serve) begin
        flag_r[bidx_r] <= 1'b1;
      end
      if (cmd.summary) begin
        cnt_r  <= '0;
        flag_r <= '0;
      end

      if (cmd.scan_start) begin
        idx_r   <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.scan_run) begin
        if (idx_r < cnt_r) begin
          pidx_r <= idx_r[IDX_W-1:0];
          idx_r  <= idx_r + CNT_W'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
        if (pend_r && !flag_r[pidx_r] && in_rng && (!found_r || key < bkey_r)) begin
          found_r <= 1'b1;
          bidx_r  <= pidx_r;
          bt_r    <= rd_q;
          bkey_r  <= key;
        end
      end

      out_valid_r <= cmd.serve || cmd.turn || cmd.summary;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.serve) begin
      out_data_r <= '{kind: dsched_pkg::KIND_SERVE, track: bt_r, seek_total: acc_nxt, last: 1'b0};
    end else if (cmd.turn) begin
      out_data_r <= '{kind: dsched_pkg::KIND_TURN, track: lim_m1, seek_total: acc_nxt,
                      last: 1'b0};
    end else if (cmd.summary) begin
      out_data_r <= '{kind: dsched_pkg::KIND_SUMMARY, track: '0, seek_total: acc_r, last: 1'b1};
    end
  end

  assign stat.scan_done = cmd.scan_run && (idx_r == cnt_r) && !pend_r;
  assign stat.found     = found_r;
  assign stat.policy    = pol_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("request count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.summary |=> (cnt_r == '0 && flag_r == '0))
    else $error("table not cleared after run");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.serve |=> (out_valid && out_data.kind == dsched_pkg::KIND_SERVE && out_data.track == head_r))
    else $error("served request not reported");

endmodule

[rtl/disk_request_scheduler_top.sv]
// Top level of the disk request scheduler: controller, datapath and port wiring.
//
//   channel | ports                            | transfer
//   --------+----------------------------------+------------------------------------
//   input   | start, busy, in_data             | edge with start high and busy low
//   result  | out_valid, out_data              | every cycle out_valid is high
//   config  | cfg_we, cfg_index, cfg_wdata     | every edge with cfg_we high
//
// A load transfer is absorbed at its accept edge and never raises busy.
// A run pass reads the request table one entry per cycle through the table's
// single read port, so each search reads every stored entry in turn before the
// controller acts on its outcome in the S_ACT state. Results are registered in
// the datapath before they reach out_valid and out_data.
// Reset is synchronous and active low; it empties the table and restores the
// register defaults. The receiver cannot stall, so results are never held.
module disk_request_scheduler_top #(
  parameter int MAX_REQUESTS = dsched_pkg::MAX_REQUESTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  dsched_pkg::in_item_t         in_data,
  output logic                         out_valid,
  output dsched_pkg::out_item_t        out_data,
  input  logic                         cfg_we,
  input  dsched_pkg::cfg_idx_t         cfg_index,
  input  logic [dsched_pkg::CYL_W-1:0] cfg_wdata
);

  // Command and status between the sequencer and the datapath.
  dsched_pkg::dp_cmd_t  cmd;
  dsched_pkg::dp_stat_t stat;

  dsched_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dsched_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sim/disk_request_scheduler_top_test.sv]
// Testbench of the disk request scheduler: directed and random traffic with a live predictor.
module disk_request_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = dsched_pkg::MAX_REQUESTS_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int TW          = dsched_pkg::TRACK_W;
  localparam int CW          = dsched_pkg::CYL_W;
  localparam int SW          = dsched_pkg::SEEK_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dsched_pkg::in_item_t in_data = '0;
  logic out_valid;
  dsched_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  dsched_pkg::cfg_idx_t cfg_index = dsched_pkg::CFG_POLICY;
  logic [CW-1:0] cfg_wdata = '0;

  disk_request_scheduler_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the scheduler state, kept in step with every accepted transfer.
  dsched_pkg::policy_t sched_policy = dsched_pkg::POL_SSTF;
  logic [CW-1:0] sched_cyl = dsched_pkg::CYL_RESET;
  logic [TW-1:0] sched_tracks [TABLE_DEPTH];
  logic sched_done [TABLE_DEPTH];
  int sched_count = 0;
  logic [TW-1:0] sched_head = '0;
  logic [SW-1:0] sched_seek = '0;

  dsched_pkg::out_item_t pending_results [$];
  int fail_count = 0;
  int cycle_count = 0;

  // The receiver cannot stall; the cycle counter serves as the run's watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    dsched_pkg::out_item_t exp_item;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: expected none, actual %p", $time, out_data);
      end else begin
        exp_item = pending_results.pop_front();
        if (exp_item.kind != out_data.kind || exp_item.track != out_data.track ||
            exp_item.seek_total != out_data.seek_total || exp_item.last != out_data.last) begin
          fail_count++;
          $display("%0t result mismatch: expected %p, actual %p", $time, exp_item, out_data);
        end
      end
    end
  end

  function automatic logic [CW-1:0] disk_limit();
    if (sched_cyl == '0) return CW'(1);
    if (sched_cyl > dsched_pkg::CYL_CAP) return dsched_pkg::CYL_CAP;
    return sched_cyl;
  endfunction

  function automatic void add_seek(logic [CW-1:0] d);
    logic [SW:0] s;
    s = {1'b0, sched_seek} + {{(SW+1-CW){1'b0}}, d};
    sched_seek = s[SW] ? dsched_pkg::SEEK_MAX : s[SW-1:0];
  endfunction

  function automatic void push_result(dsched_pkg::kind_t k, logic [TW-1:0] t, logic l);
    dsched_pkg::out_item_t r;
    r.kind = k;
    r.track = t;
    r.seek_total = sched_seek;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void service_entry(int j);
    logic [TW-1:0] t;
    t = sched_tracks[j];
    add_seek({1'b0, dsched_pkg::track_dist(sched_head, t)});
    sched_head = t;
    sched_done[j] = 1'b1;
    push_result(dsched_pkg::KIND_SERVE, t, 1'b0);
  endfunction

  // Smallest (or largest) unserviced track in [lo, hi), lowest index on ties.
  function automatic int find_entry(logic [CW-1:0] lo, logic [CW-1:0] hi, bit want_max);
    int found;
    found = -1;
    for (int j = 0; j < sched_count; j++) begin
      if (!sched_done[j] && {1'b0, sched_tracks[j]} >= lo && {1'b0, sched_tracks[j]} < hi) begin
        if (found < 0 || (want_max ? sched_tracks[j] > sched_tracks[found]
                                   : sched_tracks[j] < sched_tracks[found]))
          found = j;
      end
    end
    return found;
  endfunction

  function automatic void predict_schedule(dsched_pkg::in_item_t item);
    logic [CW-1:0] lim, lim_m1, h, best_d, d;
    int j;
    lim = disk_limit();
    lim_m1 = lim - CW'(1);
    if (item.op == dsched_pkg::OP_LOAD) begin
      if (sched_count < TABLE_DEPTH && {1'b0, item.request_track} < lim) begin
        sched_tracks[sched_count] = item.request_track;
        sched_done[sched_count] = 1'b0;
        sched_count++;
      end
      return;
    end
    h = ({1'b0, item.start_head} > lim_m1) ? lim_m1 : {1'b0, item.start_head};
    sched_head = h[TW-1:0];
    sched_seek = '0;
    if (sched_policy == dsched_pkg::POL_SSTF) begin
      for (int k = 0; k < sched_count; k++) begin
        j = -1;
        best_d = '0;
        for (int i = 0; i < sched_count; i++) begin
          if (!sched_done[i]) begin
            d = {1'b0, dsched_pkg::track_dist(sched_head, sched_tracks[i])};
            if (j < 0 || d < best_d) begin
              j = i;
              best_d = d;
            end
          end
        end
        if (j >= 0) service_entry(j);
      end
    end else begin
      for (j = find_entry(h, lim, 1'b0); j >= 0; j = find_entry(h, lim, 1'b0)) service_entry(j);
      if (sched_policy == dsched_pkg::POL_SCAN || sched_policy == dsched_pkg::POL_CSCAN) begin
        add_seek(lim_m1 - {1'b0, sched_head});
        sched_head = lim_m1[TW-1:0];
        push_result(dsched_pkg::KIND_TURN, lim_m1[TW-1:0], 1'b0);
      end
      if (sched_policy == dsched_pkg::POL_SCAN) begin
        for (j = find_entry('0, lim, 1'b1); j >= 0; j = find_entry('0, lim, 1'b1))
          service_entry(j);
      end else if (sched_policy == dsched_pkg::POL_CSCAN) begin
        add_seek(lim_m1);
        sched_head = '0;
        for (j = find_entry('0, h, 1'b0); j >= 0; j = find_entry('0, h, 1'b0)) service_entry(j);
      end else begin
        j = find_entry('0, h, 1'b0);
        if (j >= 0) begin
          add_seek({1'b0, dsched_pkg::track_dist(sched_head, sched_tracks[j])});
          sched_head = sched_tracks[j];
          for (j = find_entry('0, h, 1'b0); j >= 0; j = find_entry('0, h, 1'b0))
            service_entry(j);
        end
      end
    end
    push_result(dsched_pkg::KIND_SUMMARY, '0, 1'b1);
    sched_count = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) sched_done[i] = 1'b0;
  endfunction

  // Bursts of back-to-back transfers separated by random gaps.
  int burst_left = 0;

  // Sends one item: it is driven at a falling edge and counts as a transfer at the next
  // rising edge where busy is low. The predictor runs at that edge. Within a burst start
  // stays high and the next item follows at once.
  task automatic send_item(dsched_pkg::op_t op, logic [TW-1:0] track_val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_data.op <= op;
    in_data.request_track <= (op == dsched_pkg::OP_LOAD) ? track_val : TW'($urandom);
    in_data.start_head <= (op == dsched_pkg::OP_RUN) ? track_val : TW'($urandom);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_schedule(in_data);
    @(negedge clk);
    if (burst_left == 0) start <= 1'b0;
  endtask

  // Pause until every expected result has come, then leave the block room to settle.
  task automatic drain_results();
    if (burst_left != 0) begin
      burst_left = 0;
      start <= 1'b0;
    end
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(dsched_pkg::cfg_idx_t idx, logic [CW-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == dsched_pkg::CFG_POLICY) sched_policy = dsched_pkg::policy_t'(value[1:0]);
    else sched_cyl = value;
  endtask

  task automatic run_batch(int n_loads, logic [CW-1:0] span, logic [TW-1:0] head);
    for (int i = 0; i < n_loads; i++)
      send_item(dsched_pkg::OP_LOAD, TW'($urandom_range(0, span)));
    send_item(dsched_pkg::OP_RUN, head);
  endtask

  // Extremes, ties and dropped loads under every policy, then an empty run.
  task automatic test_directed();
    for (int p = 0; p < 4; p++) begin
      write_register(dsched_pkg::CFG_POLICY, CW'(p));
      send_item(dsched_pkg::OP_LOAD, 16'd50);
      send_item(dsched_pkg::OP_LOAD, 16'd50);
      send_item(dsched_pkg::OP_LOAD, 16'd10);
      send_item(dsched_pkg::OP_LOAD, 16'd199);
      send_item(dsched_pkg::OP_LOAD, 16'd200);   // beyond the disk, dropped
      send_item(dsched_pkg::OP_LOAD, 16'hFFFF);  // dropped
      send_item(dsched_pkg::OP_RUN, 16'd30);
    end
    send_item(dsched_pkg::OP_RUN, 16'hFFFF);     // empty run, head saturates
  endtask

  // Table overflow, full track range and edge cylinder counts.
  task automatic test_cylinder_range();
    write_register(dsched_pkg::CFG_CYL, dsched_pkg::CYL_CAP);
    for (int p = 0; p < 4; p++) begin
      write_register(dsched_pkg::CFG_POLICY, CW'(p));
      for (int i = 0; i < ((p == 0) ? 34 : 8); i++)
        send_item(dsched_pkg::OP_LOAD, (i % 3 == 0) ? 16'hFFFF : TW'($urandom));
      send_item(dsched_pkg::OP_RUN, p[0] ? 16'hFFFF : 16'h0000);
    end
    write_register(dsched_pkg::CFG_CYL, 17'h1FFFF);
    run_batch(3, 17'h0FFFF, 16'h8000);
    write_register(dsched_pkg::CFG_CYL, '0);
    run_batch(3, 17'd1, 16'd5);
    write_register(dsched_pkg::CFG_CYL, 17'd1);
    run_batch(3, 17'd1, 16'd0);
    // Lowering the count after loading leaves requests beyond the disk in the table.
    write_register(dsched_pkg::CFG_CYL, 17'd1000);
    for (int i = 0; i < 6; i++)
      send_item(dsched_pkg::OP_LOAD, TW'($urandom_range(0, 999)));
    write_register(dsched_pkg::CFG_CYL, 17'd300);
    send_item(dsched_pkg::OP_RUN, 16'd150);
  endtask

  // Random well-formed batches with a sprinkle of out-of-range loads.
  task automatic test_random();
    logic [CW-1:0] span;
    for (int b = 0; b < 9; b++) begin
      if (b % 3 == 0) write_register(dsched_pkg::CFG_POLICY, CW'($urandom_range(0, 3)));
      if (b % 5 == 0) write_register(dsched_pkg::CFG_CYL, ($urandom_range(0, 4) == 0)
                                     ? dsched_pkg::CYL_CAP : CW'($urandom_range(2, 3000)));
      span = disk_limit() + (($urandom_range(0, 5) == 0) ? CW'(20) : CW'(0));
      if (span > 17'h0FFFF) span = 17'h0FFFF;
      run_batch($urandom_range(0, 12), span, TW'($urandom_range(0, span)));
      if (b == 4) drain_results();
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sched_tracks[i] = '0;
      sched_done[i] = 1'b0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_cylinder_range();
    test_random();
    drain_results();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
rtl/dsched_pkg.sv
rtl/dsched_ctrl.sv
rtl/dsched_dp.sv
rtl/disk_request_scheduler_top.sv
sim/disk_request_scheduler_top_test.sv
